// ----- design/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/afu_pkg.sv -----
package afu_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int FRACTION_BITS = 12;
    localparam int TABLE_ENTRIES = 256;

    // internal q30 arithmetic
    localparam int Q_BITS    = 30;
    localparam int SAMPLE_W  = 32;
    localparam int SIG_W     = Q_BITS + 1;
    localparam int Q_W       = Q_BITS + 2;
    localparam int PROD_W    = 2 * SIG_W;
    localparam int TAB_IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SPAN_BITS = FRACTION_BITS + 3;
    localparam int LPROD_W   = SAMPLE_W + SPAN_BITS;
    localparam int MAG_W     = DATA_WIDTH + 1;
    localparam int POS_W     = MAG_W + TAB_IDX_W;
    localparam int OUT_SH    = Q_BITS - FRACTION_BITS;

    localparam logic [SIG_W-1:0] Q_ONE = {1'b1, {Q_BITS{1'b0}}};

    localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MAX = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE_OUT =
        (FRACTION_BITS < DATA_WIDTH - 1) ? DATA_WIDTH'(64'd1 << FRACTION_BITS) : POS_MAX;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_RELU    = 2'd0;
    localparam func_t FUNC_SIGMOID = 2'd1;
    localparam func_t FUNC_TANH    = 2'd2;
    localparam func_t FUNC_LINEAR  = 2'd3;

    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } sig_ld_t;

    typedef logic [SAMPLE_W-1:0] sig_table_t [TABLE_ENTRIES+1];

    // shift-subtract division, evaluated only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid samples on [0, 8], 64-bit wrapping arithmetic throughout
    function automatic sig_table_t build_sig_table();
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] q_one;
        sig_table_t  tab;
        q_one = 64'd1 << Q_BITS;
        d     = ((64'd8 << Q_BITS) + 64'(TABLE_ENTRIES / 2)) / TABLE_ENTRIES;
        sum   = q_one;
        term  = q_one;
        e     = q_one;
        for (int k = 1; k <= 24; k++)
        begin
            term = div_u64(term * d + 64'(k >> 1), 64'(k));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = sum;
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            den    = q_one + e;
            tab[i] = SAMPLE_W'(div_u64((q_one << Q_BITS) + (den >> 1), den));
            e      = (e * r + (q_one >> 1)) >> Q_BITS;
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ----- design/activation_function_unit.sv -----
// throughput: one word per cycle while the output is not stalled, eight-stage pipeline with per-stage valid bits
// a stalled output lets earlier stages keep filling until the pipeline is full
// reset clears the valid bits only, the sigmoid table is constant logic
`include "assert_macros.svh"

module activation_function_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  afu_pkg::func_t                        func,
    input  logic                                  want_derivative,
    input  logic signed [afu_pkg::DATA_WIDTH-1:0] operand,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [afu_pkg::DATA_WIDTH-1:0] result
);
    import afu_pkg::*;

    localparam int NUM_STAGES = 8;
    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_D = 3;
    localparam int ST_E = 4;
    localparam int ST_F = 5;
    localparam int ST_G = 6;
    localparam int ST_H = 7;

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ld;
    logic [NUM_STAGES:0]   ready;
    logic                  in_acc;
    logic                  out_acc;

    always_comb
    begin
        ready[NUM_STAGES] = !result_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
        stage_ld      = ready[NUM_STAGES-1:0];
        valid_next[0] = ready[0] ? item_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign item_stall   = !rst_n || !ready[0];
    assign result_valid = valid_reg[ST_H];
    assign in_acc       = item_valid && !item_stall;
    assign out_acc      = result_valid && !result_stall;

    // stage a: argument decode and table position
    logic signed [MAG_W-1:0] arg;
    logic [MAG_W-1:0]        mag;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        pos_sh;
    logic                    x_pos;
    logic                    a_neg_next;
    logic                    a_sat_next;
    logic [TAB_IDX_W-1:0]    a_idx_next;
    logic [SPAN_BITS-1:0]    a_frac_next;
    logic [DATA_WIDTH-1:0]   pass_next;

    logic                    a_neg_reg;
    logic                    a_sat_reg;
    logic [TAB_IDX_W-1:0]    a_idx_reg;
    logic [SPAN_BITS-1:0]    a_frac_reg;

    always_comb
    begin
        arg         = (func == FUNC_TANH) ? {operand, 1'b0} : {operand[DATA_WIDTH-1], operand};
        a_neg_next  = arg[MAG_W-1];
        mag         = a_neg_next ? MAG_W'(-arg) : MAG_W'(arg);
        a_sat_next  = (mag >> SPAN_BITS) != '0;
        pos         = POS_W'(mag) * POS_W'(TABLE_ENTRIES);
        pos_sh      = pos >> SPAN_BITS;
        a_idx_next  = pos_sh[TAB_IDX_W-1:0];
        a_frac_next = pos[SPAN_BITS-1:0];
        x_pos       = !operand[DATA_WIDTH-1] && (operand != '0);
        case (func)
            FUNC_RELU:
            begin
                if (want_derivative)
                    pass_next = x_pos ? ONE_OUT : '0;
                else
                    pass_next = x_pos ? operand : '0;
            end
            FUNC_LINEAR:
            begin
                pass_next = want_derivative ? ONE_OUT : operand;
            end
            default:
            begin
                pass_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_A])
        begin
            a_neg_reg  <= a_neg_next;
            a_sat_reg  <= a_sat_next;
            a_idx_reg  <= a_idx_next;
            a_frac_reg <= a_frac_next;
        end
    end

    // kind, derivative flag and pass-through word ride along stages a to f
    func_t                 sb_func_reg  [ST_F+1];
    logic                  sb_deriv_reg [ST_F+1];
    logic [DATA_WIDTH-1:0] sb_pass_reg  [ST_F+1];

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_A])
        begin
            sb_func_reg[ST_A]  <= func;
            sb_deriv_reg[ST_A] <= want_derivative;
            sb_pass_reg[ST_A]  <= pass_next;
        end
        for (int k = ST_B; k <= ST_F; k++)
        begin
            if (stage_ld[k])
            begin
                sb_func_reg[k]  <= sb_func_reg[k-1];
                sb_deriv_reg[k] <= sb_deriv_reg[k-1];
                sb_pass_reg[k]  <= sb_pass_reg[k-1];
            end
        end
    end

    // stages b to d: sigmoid
    sig_ld_t          sig_ld;
    logic [SIG_W-1:0] sig_s;

    assign sig_ld = '{ld_b: stage_ld[ST_B], ld_c: stage_ld[ST_C], ld_d: stage_ld[ST_D]};

    afu_sigmoid u_sigmoid (
        .clk   (clk),
        .ld    (sig_ld),
        .sat   (a_sat_reg),
        .neg   (a_neg_reg),
        .idx   (a_idx_reg),
        .frac  (a_frac_reg),
        .sig_s (sig_s)
    );

    // stage e: tanh and multiplier operands
    logic [Q_W-1:0]   t_next;
    logic [Q_W-1:0]   t_neg_val;
    logic [SIG_W-1:0] t_mag;
    logic [SIG_W-1:0] opa_next;
    logic [SIG_W-1:0] opb_next;

    logic [SIG_W-1:0] e_opa_reg;
    logic [SIG_W-1:0] e_opb_reg;
    logic [SIG_W-1:0] e_s_reg;
    logic [Q_W-1:0]   e_t_reg;

    always_comb
    begin
        t_next    = {sig_s, 1'b0} - {1'b0, Q_ONE};
        t_neg_val = -t_next;
        t_mag     = t_next[Q_W-1] ? t_neg_val[SIG_W-1:0] : t_next[SIG_W-1:0];
        if (sb_func_reg[ST_D] == FUNC_TANH)
        begin
            opa_next = t_mag;
            opb_next = t_mag;
        end
        else
        begin
            opa_next = sig_s;
            opb_next = Q_ONE - sig_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_E])
        begin
            e_opa_reg <= opa_next;
            e_opb_reg <= opb_next;
            e_s_reg   <= sig_s;
            e_t_reg   <= t_next;
        end
    end

    // stage f: product
    logic [PROD_W-1:0] f_prod_reg;
    logic [SIG_W-1:0]  f_s_reg;
    logic [Q_W-1:0]    f_t_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_F])
        begin
            f_prod_reg <= PROD_W'(e_opa_reg) * PROD_W'(e_opb_reg);
            f_s_reg    <= e_s_reg;
            f_t_reg    <= e_t_reg;
        end
    end

    // stage g: select the q30 value
    logic [PROD_W:0]       prod_rnd;
    logic [PROD_W:0]       prod_sh;
    logic [SIG_W-1:0]      sq;
    logic [Q_W-1:0]        q_next;
    logic                  bypass_next;

    logic [Q_W-1:0]        g_q_reg;
    logic                  g_bypass_reg;
    logic [DATA_WIDTH-1:0] g_pass_reg;

    always_comb
    begin
        prod_rnd    = (PROD_W + 1)'(f_prod_reg) + ((PROD_W + 1)'(1) << (Q_BITS - 1));
        prod_sh     = prod_rnd >> Q_BITS;
        sq          = (prod_sh > (PROD_W + 1)'(Q_ONE)) ? Q_ONE : prod_sh[SIG_W-1:0];
        bypass_next = 1'b0;
        case (sb_func_reg[ST_F])
            FUNC_SIGMOID:
            begin
                q_next = sb_deriv_reg[ST_F] ? {1'b0, sq} : {1'b0, f_s_reg};
            end
            FUNC_TANH:
            begin
                q_next = sb_deriv_reg[ST_F] ? {1'b0, Q_ONE - sq} : f_t_reg;
            end
            default:
            begin
                q_next      = '0;
                bypass_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_G])
        begin
            g_q_reg      <= q_next;
            g_bypass_reg <= bypass_next;
            g_pass_reg   <= sb_pass_reg[ST_F];
        end
    end

    // stage h: round to output format and saturate, or pass the relu/linear word through
    logic                  q_neg;
    logic [Q_W-1:0]        q_neg_val;
    logic [Q_W-1:0]        q_mag;
    logic [Q_W:0]          q_rnd;
    logic [DATA_WIDTH-1:0] lim;
    logic [DATA_WIDTH-1:0] rnd_sat;
    logic [DATA_WIDTH-1:0] conv;
    logic [DATA_WIDTH-1:0] result_next;
    logic [DATA_WIDTH-1:0] result_reg;

    always_comb
    begin
        q_neg       = g_q_reg[Q_W-1];
        q_neg_val   = -g_q_reg;
        q_mag       = q_neg ? q_neg_val : g_q_reg;
        q_rnd       = ((Q_W + 1)'(q_mag) + ((Q_W + 1)'(1) << (OUT_SH - 1))) >> OUT_SH;
        lim         = q_neg ? NEG_MAX : POS_MAX;
        rnd_sat     = (q_rnd > (Q_W + 1)'(lim)) ? lim : q_rnd[DATA_WIDTH-1:0];
        conv        = q_neg ? -rnd_sat : rnd_sat;
        result_next = g_bypass_reg ? g_pass_reg : conv;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ld[ST_H])
            result_reg <= result_next;
    end

    assign result = $signed(result_reg);

    `ASSERT_NEXT(a_hold_behind_stall, valid_reg[ST_H] && result_stall && valid_reg[ST_G],
        valid_reg[ST_G], "word behind a stalled output was lost")
    `ASSERT_IMPLIES(a_stall_only_full, item_stall, &valid_reg,
        "input stalled while the pipeline has a free stage")
    `ASSERT_NEXT(a_word_count, 1'b1,
        $countones(valid_reg) == $past($countones(valid_reg)) + $past(in_acc) - $past(out_acc),
        "words in flight do not match accepted minus delivered")

endmodule

// ----- design/afu_sigmoid.sv -----
module afu_sigmoid (
    input  logic                               clk,
    input  afu_pkg::sig_ld_t                   ld,
    input  logic                               sat,
    input  logic                               neg,
    input  logic [afu_pkg::TAB_IDX_W-1:0]      idx,
    input  logic [afu_pkg::SPAN_BITS-1:0]      frac,
    output logic [afu_pkg::SIG_W-1:0]          sig_s
);
    import afu_pkg::*;

    logic [TAB_IDX_W-1:0] idx_lo;
    logic [TAB_IDX_W-1:0] idx_hi;
    logic [SAMPLE_W-1:0]  lo_next;
    logic [SAMPLE_W-1:0]  diff_next;
    logic [SAMPLE_W-1:0]  interp;
    logic [SIG_W-1:0]     s_next;

    logic [SAMPLE_W-1:0]  b_lo_reg;
    logic [SAMPLE_W-1:0]  b_diff_reg;
    logic [SPAN_BITS-1:0] b_frac_reg;
    logic                 b_neg_reg;
    logic [SAMPLE_W-1:0]  c_lo_reg;
    logic [LPROD_W-1:0]   c_prod_reg;
    logic                 c_neg_reg;
    logic [SIG_W-1:0]     d_s_reg;

    // table lookup
    always_comb
    begin
        idx_lo = sat ? '0 : idx;
        idx_hi = idx_lo + TAB_IDX_W'(1);
        if (sat)
        begin
            lo_next   = SIG_TABLE[TABLE_ENTRIES];
            diff_next = '0;
        end
        else
        begin
            lo_next   = SIG_TABLE[idx_lo];
            diff_next = SIG_TABLE[idx_hi] - SIG_TABLE[idx_lo];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_b)
        begin
            b_lo_reg   <= lo_next;
            b_diff_reg <= diff_next;
            b_frac_reg <= frac;
            b_neg_reg  <= neg;
        end
    end

    // interpolation product
    always_ff @(posedge clk)
    begin
        if (ld.ld_c)
        begin
            c_lo_reg   <= b_lo_reg;
            c_prod_reg <= LPROD_W'(b_diff_reg) * LPROD_W'(b_frac_reg);
            c_neg_reg  <= b_neg_reg;
        end
    end

    // round, add and mirror for negative arguments
    always_comb
    begin
        interp = c_lo_reg
            + SAMPLE_W'((c_prod_reg + (LPROD_W'(1) << (SPAN_BITS - 1))) >> SPAN_BITS);
        s_next = c_neg_reg ? Q_ONE - interp[SIG_W-1:0] : interp[SIG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_d)
            d_s_reg <= s_next;
    end

    assign sig_s = d_s_reg;

endmodule

// ----- bench/afu_result_monitor.sv -----
module afu_result_monitor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  logic                                  item_stall,
    input  afu_pkg::func_t                        func,
    input  logic                                  want_derivative,
    input  logic signed [afu_pkg::DATA_WIDTH-1:0] operand,
    input  logic                                  result_valid,
    input  logic                                  result_stall,
    input  logic signed [afu_pkg::DATA_WIDTH-1:0] result,
    output int                                    mismatch_count,
    output int                                    outstanding
);
    import afu_pkg::*;

    localparam int     DW        = DATA_WIDTH;
    localparam int     FB        = FRACTION_BITS;
    localparam int     TE        = TABLE_ENTRIES;
    localparam int     QB        = 30;
    localparam int     DROP      = QB - FB;
    localparam longint SPAN      = longint'(8) << FB;
    localparam longint Q1        = longint'(1) << QB;
    localparam longint POS_LIMIT = (longint'(1) << (DW - 1)) - 1;
    localparam longint NEG_LIMIT = longint'(1) << (DW - 1);
    localparam longint UNIT_WORD =
        ((longint'(1) << FB) > POS_LIMIT) ? POS_LIMIT : (longint'(1) << FB);

    longint        sig_samples [0:TE];
    logic [DW-1:0] expected_words [$];
    int            errors = 0;

    // sigmoid samples on [0, 8] from a series for exp(-8/TE)
    initial
    begin
        longint step;
        longint term;
        longint series;
        longint ratio;
        longint ex;
        longint den;
        step   = ((longint'(8) << QB) + TE / 2) / TE;
        series = Q1;
        term   = Q1;
        ex     = Q1;
        for (int k = 1; k <= 24; k++)
        begin
            term = (term * step + k / 2) / k;
            if (k % 2 == 1)
                series = series - term;
            else
                series = series + term;
        end
        ratio = series;
        for (int i = 0; i <= TE; i++)
        begin
            den            = Q1 + ex;
            sig_samples[i] = ((Q1 << QB) + den / 2) / den;
            ex             = (ex * ratio + Q1 / 2) >>> QB;
        end
    end

    function automatic longint sigmoid_of_magnitude(input longint mag);
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        if (mag >= SPAN)
            return sig_samples[TE];
        pos  = mag * TE;
        idx  = pos / SPAN;
        frac = pos % SPAN;
        if (idx >= TE)
            return sig_samples[TE];
        lo = sig_samples[idx];
        hi = sig_samples[idx + 1];
        return lo + ((hi - lo) * frac + SPAN / 2) / SPAN;
    endfunction

    function automatic longint sigmoid_q30(input longint x);
        if (x < 0)
            return Q1 - sigmoid_of_magnitude(-x);
        return sigmoid_of_magnitude(x);
    endfunction

    // q30 to word format, round half away from zero, saturate
    function automatic logic [DW-1:0] q30_to_word(input longint q);
        logic   neg;
        longint mag;
        longint rnd;
        neg = q < 0;
        mag = neg ? -q : q;
        rnd = (mag + (longint'(1) << (DROP - 1))) >>> DROP;
        if (neg && rnd > NEG_LIMIT)
            rnd = NEG_LIMIT;
        if (!neg && rnd > POS_LIMIT)
            rnd = POS_LIMIT;
        return DW'(neg ? -rnd : rnd);
    endfunction

    function automatic logic [DW-1:0] activation_word(input func_t f, input logic deriv,
                                                      input logic signed [DW-1:0] op);
        longint x;
        longint s;
        longint t;
        longint m;
        longint sq;
        x = longint'(op);
        case (f)
            FUNC_RELU:
                if (deriv)
                    return (x > 0) ? DW'(UNIT_WORD) : '0;
                else
                    return (x > 0) ? op : '0;
            FUNC_SIGMOID:
            begin
                s = sigmoid_q30(x);
                if (deriv)
                    return q30_to_word((s * (Q1 - s) + Q1 / 2) >>> QB);
                return q30_to_word(s);
            end
            FUNC_TANH:
            begin
                t = 2 * sigmoid_q30(2 * x) - Q1;
                if (deriv)
                begin
                    m  = (t < 0) ? -t : t;
                    sq = (m * m + Q1 / 2) >>> QB;
                    if (sq > Q1)
                        sq = Q1;
                    return q30_to_word(Q1 - sq);
                end
                return q30_to_word(t);
            end
            default:
                return deriv ? DW'(UNIT_WORD) : op;
        endcase
    endfunction

    always @(posedge clk)
    begin
        logic [DW-1:0] want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_words.push_back(activation_word(func, want_derivative, operand));
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none actual %0d",
                             $time, $signed(result));
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: result mismatch, expected %0d actual %0d",
                                 $time, $signed(want), $signed(result));
                        errors++;
                    end
                end
            end
        end
        outstanding    <= expected_words.size();
        mismatch_count <= errors;
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import afu_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_WORDS = 1000;
    localparam int SETTLE       = 20;

    localparam logic [DATA_WIDTH-1:0] EDGE_OPS [8] = '{
        16'h0000, 16'h0001, 16'hffff, 16'h4000,
        16'hc000, 16'h1000, 16'hf000, 16'h0080
    };
    localparam func_t ALL_FUNCS [4] = '{FUNC_RELU, FUNC_SIGMOID, FUNC_TANH, FUNC_LINEAR};

    logic                         clk             = 1'b0;
    logic                         rst_n           = 1'b0;
    logic                         item_valid      = 1'b0;
    func_t                        func            = FUNC_RELU;
    logic                         want_derivative = 1'b0;
    logic signed [DATA_WIDTH-1:0] operand         = '0;
    logic                         result_stall    = 1'b1;
    logic                         item_stall;
    logic                         result_valid;
    logic signed [DATA_WIDTH-1:0] result;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    always #5 clk = ~clk;

    activation_function_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .func            (func),
        .want_derivative (want_derivative),
        .operand         (operand),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result)
    );

    afu_result_monitor result_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .func            (func),
        .want_derivative (want_derivative),
        .operand         (operand),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatch_count  (fail_count),
        .outstanding     (outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_word(input func_t f, input logic d, input logic [DATA_WIDTH-1:0] op);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid      <= 1'b1;
        func            <= f;
        want_derivative <= d;
        operand         <= op;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 9)) inside
            [0:4]:
                return DATA_WIDTH'($urandom);
            [5:7]:
                return DATA_WIDTH'(int'($urandom_range(0, 16384)) - 8192);
            8:
                // around table sample points
                return DATA_WIDTH'((int'($urandom_range(0, 511)) - 256) * 128
                                   + int'($urandom_range(0, 2)) - 1);
            default:
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h8001;
                    default: return 16'h0000;
                endcase
        endcase
    endfunction

    // result side
    initial
    begin
        int hold;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 8; k++)
        begin
            send_word(ALL_FUNCS[k / 2], 1'(k % 2), 16'h8000);
            send_word(ALL_FUNCS[k / 2], 1'(k % 2), 16'h7fff);
            send_word(ALL_FUNCS[k / 2], 1'(k % 2), EDGE_OPS[k]);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_WORDS / 2)
            begin
                // drain the pipeline before going on
                item_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            send_word(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      pick_operand());
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- activation_function_unit.f -----
+incdir+design
design/afu_pkg.sv
design/afu_sigmoid.sv
design/activation_function_unit.sv
bench/afu_result_monitor.sv
bench/tb_top.sv
